// File: design/tbrl_pkg.sv
// tbrl_pkg: shared types, field widths, codes and the refill constant table
// for the token bucket rate limiter. No dependencies.
`default_nettype none

package tbrl_pkg;

	// Field widths
	localparam int LIMIT_W  = 16;
	localparam int KIND_W   = 2;
	localparam int MS_W     = 10;
	localparam int BYTES_W  = 40;
	localparam int STATUS_W = 2;
	localparam int LEFT_W   = 36;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TRY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WAIT = 2'd2;

	// Result codes
	localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_REFUSED   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_WAIT_DONE = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_WAIT_BUSY = 2'd3;

	// One MiB is 2^20 bytes
	localparam int MIB_SHIFT = 20;

	// Refill = floor(limit * ms * 2^20 / 1000) = floor(P * 2^17 / 125), P = limit * ms.
	// P = 125*q + r gives q * 2^17 + floor(r * 2^17 / 125).
	localparam int PROD_W      = LIMIT_W + MS_W;   // P
	localparam int DIV_MS      = 125;
	localparam int FRAC_SHIFT  = 17;
	localparam int QUOT_W      = 20;               // q < 2^26 / 125
	localparam int REM_W       = 7;                // r < 125
	localparam int RECIP_W     = 27;
	localparam int RECIP_SHIFT = 33;
	// ceil(2^33 / 125); exact quotient for every 26-bit P
	localparam logic [RECIP_W-1:0] RECIP_125 = 27'd68719477;
	localparam int ADD_W       = 37;               // largest refill < 2^37
	localparam int FRAC_W      = 17;
	localparam int LUT_DEPTH   = 1 << REM_W;

	typedef logic [LUT_DEPTH-1:0][FRAC_W-1:0] frac_lut_t;

	function automatic frac_lut_t build_frac_lut();
		frac_lut_t lut;
		for (int i = 0; i < LUT_DEPTH; i++) begin
			lut[i] = (i < DIV_MS) ? FRAC_W'((i << FRAC_SHIFT) / DIV_MS) : '0;
		end
		return lut;
	endfunction

	// floor(r * 2^17 / 125) for each remainder
	localparam frac_lut_t FRAC_LUT = build_frac_lut();

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [MS_W-1:0]    delta_ms;
		logic [BYTES_W-1:0] byte_count;
	} tbrl_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LEFT_W-1:0]   tokens_left;
	} tbrl_out_t;

	// Stage load strobes from the top-level flow control
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic fire_s4;
	} tbrl_adv_t;

endpackage

`default_nettype wire

// File: design/token_bucket_rate_limiter_unit.sv
// Token bucket rate limiter, top level: input register, stage flow control,
// limit register. Depends on tbrl_pkg, tbrl_refill_pipe, tbrl_bucket_core.
// Beats pass the input register, stages 2..4 and the result register. Throughput:
// one beat per cycle unless the result channel stalls; the refill math (multiply,
// reciprocal divide by 125, table) is pipelined ahead of the bucket update, which sets the rate.
// Reset (arst_n low, async): limit 0 (unlimited), bucket empty, no wait pending.
`default_nettype none

module token_bucket_rate_limiter_unit
	import tbrl_pkg::*;
#(
	parameter int TOKEN_WIDTH   = 37,
	parameter int REQUEST_WIDTH = 40
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tbrl_in_t           in_data,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output tbrl_out_t               out_data,
	// limit register, MiB/s; writing it refills the bucket
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata
);

	logic [LIMIT_W-1:0] limit_q;
	tbrl_in_t           item_s1, item_s4;
	logic [ADD_W-1:0]   addend_s4;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic               out_free, rdy1, rdy2, rdy3, rdy4;
	tbrl_adv_t          adv;

	// A stage may load when it is empty or its beat moves on this cycle.
	// Bubbles collapse, so the front keeps taking beats while a result
	// sits in the output register.
	assign out_free = !out_valid || !out_stall;
	assign rdy4     = !v_s4 || out_free;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	assign adv.ld_s2   = rdy2 && v_s1;
	assign adv.ld_s3   = rdy3 && v_s2;
	assign adv.ld_s4   = rdy4 && v_s3;
	assign adv.fire_s4 = v_s4 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			item_s1 <= in_data;
		end
	end

	tbrl_refill_pipe u_refill (
		.clk       (clk),
		.limit     (limit_q),
		.item_s1   (item_s1),
		.adv       (adv),
		.item_s4   (item_s4),
		.addend_s4 (addend_s4)
	);

	tbrl_bucket_core #(
		.TOKEN_WIDTH   (TOKEN_WIDTH),
		.REQUEST_WIDTH (REQUEST_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit_q),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.item_s4   (item_s4),
		.addend_s4 (addend_s4),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: design/tbrl_refill_pipe.sv
// tbrl_refill_pipe: stages 2..4 that turn limit * delta_ms into the refill
// byte count, carrying the beat along. Depends on tbrl_pkg.
`default_nettype none

module tbrl_refill_pipe
	import tbrl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic [LIMIT_W-1:0] limit,
	input  wire tbrl_in_t           item_s1,
	input  wire tbrl_adv_t          adv,
	output tbrl_in_t                item_s4,
	output logic [ADD_W-1:0]        addend_s4
);

	localparam int RP_W = PROD_W + RECIP_W;

	tbrl_in_t              item_s2, item_s3;
	logic [PROD_W-1:0]     prod, prod_s2, prod_s3;
	logic [RP_W-1:0]       recip_prod;
	logic [QUOT_W-1:0]     quot, quot_s3;
	logic [PROD_W-1:0]     rem_full;
	logic [REM_W-1:0]      rem;
	logic [ADD_W-1:0]      addend;

	// stage 1 -> 2: limit * ms
	assign prod = PROD_W'(limit) * PROD_W'(item_s1.delta_ms);

	// stage 2 -> 3: quotient by 125 through the reciprocal
	assign recip_prod = RP_W'(prod_s2) * RP_W'(RECIP_125);
	assign quot       = recip_prod[RECIP_SHIFT +: QUOT_W];

	// stage 3 -> 4: remainder, table lookup for the fractional part
	assign rem_full = prod_s3 - PROD_W'(quot_s3) * PROD_W'(DIV_MS);
	assign rem      = rem_full[REM_W-1:0];
	assign addend   = (ADD_W'(quot_s3) << FRAC_SHIFT) + ADD_W'(FRAC_LUT[rem]);

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			item_s2 <= item_s1;
			prod_s2 <= prod;
		end
		if (adv.ld_s3) begin
			item_s3 <= item_s2;
			prod_s3 <= prod_s2;
			quot_s3 <= quot;
		end
		if (adv.ld_s4) begin
			item_s4   <= item_s3;
			addend_s4 <= addend;
		end
	end

endmodule

`default_nettype wire

// File: design/tbrl_bucket_core.sv
// tbrl_bucket_core: bucket level, pending wait state and the result register.
// Depends on tbrl_pkg; fed by tbrl_refill_pipe.
`default_nettype none

module tbrl_bucket_core
	import tbrl_pkg::*;
#(
	parameter int TOKEN_WIDTH   = 37,
	parameter int REQUEST_WIDTH = 40
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [LIMIT_W-1:0] limit,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	input  wire tbrl_adv_t          adv,
	input  wire tbrl_in_t           item_s4,
	input  wire logic [ADD_W-1:0]   addend_s4,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output tbrl_out_t               out_data
);

	localparam int RAW_W = LIMIT_W + MIB_SHIFT;
	localparam int CAP_W = (TOKEN_WIDTH > RAW_W) ? TOKEN_WIDTH : RAW_W;
	localparam int SUM_W = ((TOKEN_WIDTH > ADD_W) ? TOKEN_WIDTH : ADD_W) + 1;
	localparam int CMP_W = (TOKEN_WIDTH > REQUEST_WIDTH) ? TOKEN_WIDTH : REQUEST_WIDTH;
	localparam logic [TOKEN_WIDTH-1:0] TOKEN_ALL1 = '1;

	function automatic logic [TOKEN_WIDTH-1:0] cap_of(input logic [LIMIT_W-1:0] lim);
		logic [CAP_W-1:0] raw;
		raw = CAP_W'(lim) << MIB_SHIFT;
		return (raw > CAP_W'(TOKEN_ALL1)) ? TOKEN_ALL1 : TOKEN_WIDTH'(raw);
	endfunction

	logic [TOKEN_WIDTH-1:0]   token_level_q, lvl_ref, lvl_chunk, lvl_new, cap;
	logic [REQUEST_WIDTH-1:0] wait_rem_q, wr_src, wr_after, wr_new, bytes;
	logic                     wait_pend_q, pend_new;
	logic [SUM_W-1:0]         sum;
	logic [CMP_W-1:0]         chunk;
	logic                     unlimited, paid, chunk_done, try_ok, has_res;
	logic [STATUS_W-1:0]      status;

	assign cap       = cap_of(limit);
	assign unlimited = (limit == '0);
	assign bytes     = REQUEST_WIDTH'(item_s4.byte_count);

	always_comb begin
		// refill, saturating at capacity; the level is kept as is while unlimited
		sum     = SUM_W'(token_level_q) + SUM_W'(addend_s4);
		lvl_ref = token_level_q;
		if (!unlimited) begin
			lvl_ref = (sum > SUM_W'(cap)) ? cap : TOKEN_WIDTH'(sum);
		end

		// one wait chunk: a new wait pays from its own bytes, a tick from the pending rest
		wr_src     = (item_s4.kind == KIND_WAIT) ? bytes : wait_rem_q;
		chunk      = (CMP_W'(wr_src) < CMP_W'(cap)) ? CMP_W'(wr_src) : CMP_W'(cap);
		paid       = CMP_W'(lvl_ref) >= chunk;
		wr_after   = unlimited ? '0 : (paid ? wr_src - REQUEST_WIDTH'(chunk) : wr_src);
		lvl_chunk  = (!unlimited && paid) ? lvl_ref - TOKEN_WIDTH'(chunk) : lvl_ref;
		chunk_done = (wr_after == '0);
		try_ok     = CMP_W'(lvl_ref) >= CMP_W'(bytes);

		lvl_new  = lvl_ref;
		wr_new   = wait_rem_q;
		pend_new = wait_pend_q;
		has_res  = 1'b0;
		status   = STATUS_GRANTED;

		unique case (item_s4.kind)
			KIND_TICK: begin
				if (wait_pend_q) begin
					lvl_new = lvl_chunk;
					wr_new  = wr_after;
					if (chunk_done) begin
						pend_new = 1'b0;
						has_res  = 1'b1;
						status   = STATUS_WAIT_DONE;
					end
				end
			end
			KIND_TRY: begin
				has_res = 1'b1;
				if (unlimited) begin
					status = STATUS_GRANTED;
				end else if (try_ok) begin
					lvl_new = lvl_ref - TOKEN_WIDTH'(bytes);
					status  = STATUS_GRANTED;
				end else begin
					status = STATUS_REFUSED;
				end
			end
			KIND_WAIT: begin
				if (wait_pend_q) begin
					has_res = 1'b1;
					status  = STATUS_WAIT_BUSY;
				end else begin
					lvl_new = lvl_chunk;
					wr_new  = wr_after;
					if (chunk_done) begin
						has_res = 1'b1;
						status  = STATUS_WAIT_DONE;
					end else begin
						pend_new = 1'b1;
					end
				end
			end
			default: begin
				// refill only
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_level_q <= '0;
			wait_rem_q    <= '0;
			wait_pend_q   <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_we) begin
				token_level_q <= cap_of(cfg_wdata);
			end else if (adv.fire_s4) begin
				token_level_q <= lvl_new;
			end
			if (adv.fire_s4) begin
				wait_rem_q  <= wr_new;
				wait_pend_q <= pend_new;
			end
			if (adv.fire_s4 && has_res) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.fire_s4 && has_res) begin
			out_data.status      <= status;
			out_data.tokens_left <= LEFT_W'(lvl_new);
		end
	end

`ifndef SYNTH
	a_level_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		token_level_q <= cap)
		else $error("bucket level above capacity");

	a_unlimited_empty: assert property (@(posedge clk) disable iff (!arst_n)
		unlimited |-> token_level_q == '0)
		else $error("bucket not empty while unlimited");

	a_pending_has_rest: assert property (@(posedge clk) disable iff (!arst_n)
		wait_pend_q |-> wait_rem_q != '0)
		else $error("wait pending with nothing left to pay");

	a_second_wait_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv.fire_s4 && item_s4.kind == KIND_WAIT && wait_pend_q
		|=> out_valid && out_data.status == STATUS_WAIT_BUSY)
		else $error("second wait not answered busy");
`endif

endmodule

`default_nettype wire

// File: tb/tbrl_bucket_checker.sv
// tbrl_bucket_checker: watches the request, result and limit ports of the
// token bucket rate limiter, predicts each result and compares it.
// Depends on tbrl_pkg.
`timescale 1ns / 100ps

module tbrl_bucket_checker
	import tbrl_pkg::*;
#(
	parameter int TOKEN_WIDTH   = 37,
	parameter int REQUEST_WIDTH = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  tbrl_in_t           in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  tbrl_out_t          out_data,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	output int                 fail_count,
	output int                 verdicts_owed,
	output int                 verdicts_seen
);

	localparam logic [63:0] TOKEN_CEIL   = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TOKEN_WIDTH);
	localparam logic [63:0] REQUEST_CEIL = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - REQUEST_WIDTH);
	localparam logic [63:0] MS_PER_S     = 64'd1000;

	// Shadow copy of the block's state
	logic [LIMIT_W-1:0] rate_mib;
	logic [63:0]        level;
	logic [63:0]        debt;
	bit                 waiting;

	tbrl_out_t verdict_q[$];
	tbrl_out_t want;
	int        errs;
	int        seen;

	assign fail_count    = errs;
	assign verdicts_seen = seen;

	function automatic logic [63:0] bucket_size();
		logic [63:0] c;
		c = 64'(rate_mib) << MIB_SHIFT;
		return (c > TOKEN_CEIL) ? TOKEN_CEIL : c;
	endfunction

	// one chunk of the outstanding wait; true once it is fully paid
	function automatic bit pay_down();
		logic [63:0] chunk;
		if (rate_mib == '0) begin
			debt = '0;
			return 1'b1;
		end
		chunk = (debt < bucket_size()) ? debt : bucket_size();
		if (level >= chunk) begin
			level -= chunk;
			debt  -= chunk;
		end
		return debt == '0;
	endfunction

	task automatic charge_bucket(input tbrl_in_t beat);
		logic [63:0] nbytes;
		logic [63:0] gain;
		logic [63:0] cap;
		tbrl_out_t   v;
		bit          emit;
		nbytes = 64'(beat.byte_count) & REQUEST_CEIL;
		cap    = bucket_size();
		if (rate_mib != '0 && beat.delta_ms != '0) begin
			gain  = (64'(rate_mib) * (64'd1 << MIB_SHIFT) * 64'(beat.delta_ms)) / MS_PER_S;
			level = (level + gain > cap) ? cap : level + gain;
		end
		emit = 1'b1;
		v    = '0;
		case (beat.kind)
			KIND_TICK: begin
				if (waiting && pay_down()) begin
					waiting  = 1'b0;
					v.status = STATUS_WAIT_DONE;
				end else begin
					emit = 1'b0;
				end
			end
			KIND_TRY: begin
				if (rate_mib == '0) begin
					v.status = STATUS_GRANTED;
				end else if (level >= nbytes) begin
					level   -= nbytes;
					v.status = STATUS_GRANTED;
				end else begin
					v.status = STATUS_REFUSED;
				end
			end
			KIND_WAIT: begin
				if (waiting) begin
					v.status = STATUS_WAIT_BUSY;
				end else begin
					debt = nbytes;
					if (pay_down()) begin
						v.status = STATUS_WAIT_DONE;
					end else begin
						waiting = 1'b1;
						emit    = 1'b0;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		if (emit) begin
			v.tokens_left = level[LEFT_W-1:0];
			verdict_q.push_back(v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_mib = '0;
			level    = '0;
			debt     = '0;
			waiting  = 1'b0;
			verdict_q.delete();
			verdicts_owed <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen++;
				if (verdict_q.size() == 0) begin
					$error("unexpected result beat: status %0d tokens_left %0d",
						out_data.status, out_data.tokens_left);
					errs++;
				end else begin
					want = verdict_q.pop_front();
					if (out_data.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, out_data.status);
						errs++;
					end
					if (out_data.tokens_left !== want.tokens_left) begin
						$error("tokens_left mismatch: expected %0d, actual %0d",
							want.tokens_left, out_data.tokens_left);
						errs++;
					end
				end
			end
			// a limit write refills the bucket to the new capacity
			if (cfg_we) begin
				rate_mib = cfg_wdata;
				level    = bucket_size();
			end
			if (in_valid && !in_stall)
				charge_bucket(in_data);
			verdicts_owed <= verdict_q.size();
		end
	end

endmodule

// File: tb/token_bucket_rate_limiter_unit_tb.sv
// token_bucket_rate_limiter_unit_tb: stimulus, flow-control pressure and the
// verdict for the token bucket rate limiter. Depends on tbrl_pkg, the block
// itself and tbrl_bucket_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module token_bucket_rate_limiter_unit_tb
	import tbrl_pkg::*;
();

	// kind 3 is not a request: the block only refills on it
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	localparam int PHASES       = 9;
	localparam int PER_PHASE    = 75;    // random beats per limit setting
	localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 8;     // pipeline depth plus margin
	localparam int STUCK_LIMIT  = 2000;  // cycles with no beat on either side
	localparam logic [BYTES_W-1:0] MIB = 40'd1 << MIB_SHIFT;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	tbrl_in_t           in_data;
	logic               out_valid;
	logic               out_stall;
	tbrl_out_t          out_data;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	int fail_count;
	int verdicts_owed;
	int verdicts_seen;

	// knobs and counters used by the sender, receiver and watchdog processes
	int                 gap_pct     = 20;
	bit                 quiet       = 1'b0;
	bit                 hold_req    = 1'b0;
	bit                 hold_served = 1'b0;
	int                 beats_sent  = 0;
	int                 settings    = 0;
	int                 stuck       = 0;
	logic [LIMIT_W-1:0] cur_limit   = '0;

	token_bucket_rate_limiter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	tbrl_bucket_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.verdicts_owed (verdicts_owed),
		.verdicts_seen (verdicts_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stall bursts and ready runs, one long hold-off on
	// request, nothing at all once the run goes quiet. Every branch waits on
	// the clock before the next step, so out_stall gets one update per step.
	initial begin
		forever begin
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Watchdog: any accepted beat on either side counts as progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck <= 0;
		end else if (stuck == STUCK_LIMIT) begin
			$display("token_bucket_rate_limiter_unit regression: fail");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	// Offer one request beat, maybe after an idle burst, and hold it until
	// the block takes it. Valid stays high into the next beat when there is
	// no gap, so it is never lowered and raised in the same step.
	task automatic offer(input logic [KIND_W-1:0] k, input logic [MS_W-1:0] ms,
		input logic [BYTES_W-1:0] nb);
		tbrl_in_t b;
		b.kind       = k;
		b.delta_ms   = ms;
		b.byte_count = nb;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	// Stop offering, wait for every owed result, then give beats that make no
	// result time to leave the pipe (only cycles without back-pressure count).
	task automatic drain_block();
		int n;
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_owed != 0) @(posedge clk);
		n = 0;
		while (n < DRAIN_CYCLES) begin
			@(posedge clk);
			if (!out_stall)
				n++;
		end
	endtask

	// Limit writes only happen with the block idle
	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_limit = v;
		settings++;
	endtask

	initial begin : stimulus
		logic [LIMIT_W-1:0] phase_limits [PHASES];
		longint unsigned    cap;
		int                 phase;
		int                 n;
		int                 k;
		int                 pick;
		logic [MS_W-1:0]    ms;
		logic [KIND_W-1:0]  kd;
		logic [BYTES_W-1:0] nb;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: unlimited out of reset ----
		offer(KIND_TRY, 10'd0, '0);
		offer(KIND_TRY, 10'd1023, '1);      // anything is granted when unlimited
		offer(KIND_WAIT, 10'd0, '1);        // wait completes at once
		offer(KIND_TICK, 10'd5, '0);        // tick with nothing pending: no result
		offer(KIND_SPARE, 10'd1023, '1);    // reserved kind: refill only

		// ---- 1 MiB/s: capacity edges and a wait paid in chunks ----
		write_limit(16'd1);
		offer(KIND_TRY, 10'd0, MIB + 40'd1);  // one byte over capacity: refused
		offer(KIND_TRY, 10'd0, MIB);          // exactly capacity: empties bucket
		offer(KIND_TRY, 10'd0, '0);
		offer(KIND_WAIT, 10'd0, 3 * MIB);     // first chunk cannot pay: goes pending
		offer(KIND_WAIT, 10'd0, 40'd5);       // second wait while pending: busy
		offer(KIND_TRY, 10'd1, 40'd1);        // try still served while pending
		offer(KIND_TICK, 10'd1023, '0);       // full refill pays one chunk, silent
		offer(KIND_SPARE, 10'd500, '0);

		// limit change keeps the wait pending; bigger chunk finishes it
		write_limit(16'd2);
		offer(KIND_TICK, 10'd0, '0);
		offer(KIND_WAIT, 10'd0, '0);          // zero-byte wait completes at once
		offer(KIND_WAIT, 10'd0, 10 * MIB);
		write_limit(16'd0);                   // going unlimited completes it on a tick
		offer(KIND_TICK, 10'd7, '0);

		// ---- top rate ----
		write_limit(16'hFFFF);
		offer(KIND_TRY, 10'd0, '1);
		offer(KIND_TRY, 10'd0, BYTES_W'(64'hFFFF << MIB_SHIFT));
		offer(KIND_TICK, 10'd1023, '0);
		offer(KIND_WAIT, 10'd0, '1);          // huge wait, left pending
		write_limit(16'd0);
		offer(KIND_TICK, 10'd0, '0);          // and released by unlimited

		// ---- random phases, one limit setting each ----
		phase_limits[0] = 16'd1;
		phase_limits[1] = 16'hFFFF;
		phase_limits[2] = 16'd3;
		phase_limits[3] = 16'd0;
		phase_limits[4] = 16'd40000;
		phase_limits[5] = LIMIT_W'($urandom_range(4, 65534));
		phase_limits[6] = LIMIT_W'($urandom_range(4, 255));
		phase_limits[7] = 16'd2;
		phase_limits[8] = 16'hFFFF;

		for (phase = 0; phase < PHASES; phase++) begin
			write_limit(phase_limits[phase]);
			gap_pct = (phase % 3) * 20;
			quiet   = (phase == PHASES - 1);   // last stretch runs flat out
			cap     = longint'(cur_limit) << MIB_SHIFT;
			n       = 0;
			while (n < PER_PHASE) begin
				// receiver holds off for a long stretch while we keep offering
				if (phase == 1 && n >= 20)
					hold_req = 1'b1;
				// sender steps back until every owed result is in
				if (phase == 4 && n == 40)
					drain_block();

				pick = $urandom_range(0, 99);
				if (pick < 25 && cap != 0) begin
					// paced wait: a few chunks, then ticks that refill fully
					k = $urandom_range(1, 3);
					offer(KIND_WAIT, MS_W'($urandom_range(0, 1023)),
						BYTES_W'(cap * k + $urandom_range(0, 1 << 20)));
					repeat (k + 2)
						offer(KIND_TICK, MS_W'($urandom_range(1000, 1023)),
							BYTES_W'($urandom));
					n += k + 3;
				end else begin
					case ($urandom_range(0, 3))
						0:       ms = '0;
						1:       ms = MS_W'($urandom_range(1000, 1023));
						default: ms = MS_W'($urandom_range(0, 1023));
					endcase
					pick = $urandom_range(0, 99);
					if (pick < 30)
						kd = KIND_TICK;
					else if (pick < 65)
						kd = KIND_TRY;
					else if (pick < 94)
						kd = KIND_WAIT;
					else
						kd = KIND_SPARE;
					case ($urandom_range(0, 3))
						0:       nb = BYTES_W'({$urandom, $urandom});
						1:       nb = BYTES_W'(cap * $urandom_range(0, 1024) / 1024);
						2:       nb = BYTES_W'($urandom_range(0, 4095));
						default: nb = BYTES_W'(cap + $urandom_range(0, 1));
					endcase
					// keep waits payable at a real rate, or the phase locks up busy
					if (kd == KIND_WAIT && cap != 0 && nb > 4 * cap)
						nb = BYTES_W'(cap * $urandom_range(0, 4) + $urandom_range(0, 4095));
					offer(kd, ms, nb);
					n++;
				end
			end
		end

		drain_block();

		$display("covered %0d request beats across %0d limit settings, unlimited and full rate",
			beats_sent, settings);
		$display("with chunked waits, busy and refused paths; %0d result beats compared",
			verdicts_seen);
		if (fail_count == 0)
			$display("token_bucket_rate_limiter_unit regression: pass");
		else
			$display("token_bucket_rate_limiter_unit regression: fail");
		$finish;
	end

endmodule

// File: token_bucket_rate_limiter_unit.f
design/tbrl_pkg.sv
design/tbrl_refill_pipe.sv
design/tbrl_bucket_core.sv
design/token_bucket_rate_limiter_unit.sv
tb/tbrl_bucket_checker.sv
tb/token_bucket_rate_limiter_unit_tb.sv
